>>> hdl/kptm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kptm_pkg
// Shared types and constants of the keyboard port and tone meter.
// ----------------------------------------------------------------------------
package kptm_pkg;

   localparam int DEF_KEY_ROWS     = 8;
   localparam int DEF_KEYS_PER_ROW = 5;

   localparam int KIND_W   = 2;
   localparam int ADDR_W   = 16;
   localparam int TIME_W   = 20;
   localparam int MATRIX_W = 40;
   localparam int DATA_W   = 8;
   localparam int FREQ_W   = 24;
   localparam int RATE_W   = 25;
   localparam int COUNT_W  = 16;
   localparam int TOTAL_W  = 32;

   // dividend is (rate / 2) * count
   localparam int QUOT_W    = RATE_W - 1 + COUNT_W;
   localparam int STEP_CNT_W = $clog2(QUOT_W);

   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(3250000);
   localparam logic [7:0]        KBD_PORT   = 8'hFE;
   localparam logic [DATA_W-1:0] IDLE_READ  = 8'hFF;
   localparam logic [FREQ_W-1:0] FREQ_MAX   = '1;

   localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SYNC  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } kptm_state_type;

   typedef struct packed {
      logic accept;
      logic mul;
      logic div_step;
      logic load_simple;
      logic load_freq;
   } kptm_cmd_type;

   typedef struct packed {
      logic req_is_sync;
   } kptm_status_type;

endpackage

>>> hdl/kptm_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kptm channels
// Request and response channels with valid / ready handshake.
// ----------------------------------------------------------------------------
interface kptm_req_if import kptm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [ADDR_W-1:0]   port_address;
   logic [TIME_W-1:0]   cycle_now;
   logic [MATRIX_W-1:0] key_matrix;

   modport source (output valid, output kind, output port_address, output cycle_now,
                   output key_matrix, input ready);
   modport sink (input valid, input kind, input port_address, input cycle_now,
                 input key_matrix, output ready);
endinterface

interface kptm_rsp_if import kptm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic [FREQ_W-1:0] tone_frequency;
   logic              tone_update;

   modport source (output valid, output read_data, output tone_frequency,
                   output tone_update, input ready);
   modport sink (input valid, input read_data, input tone_frequency,
                 input tone_update, output ready);
endinterface

>>> hdl/keyboard_port_and_tone_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_port_and_tone_meter
// Keyboard / speaker port at 0xFE with a speaker tone meter.
// ----------------------------------------------------------------------------
// Reads, writes and unused kinds: response registered in the cycle after the request is taken,
// one request per cycle while the response side keeps up.
// Frame sync: response registered from the done state after the 24x16 multiply
// and the one-bit-per-cycle 40-step divider; next request taken back in idle.
// A new request is taken only in a cycle where no response waits or the waiting one
// is taken; a stalled response holds off requests and a finished sync alike.
// Synchronous reset clears toggle state and sets the clock rate to 3250000.
module keyboard_port_and_tone_meter import kptm_pkg::*; #(
   parameter int KEY_ROWS     = DEF_KEY_ROWS,
   parameter int KEYS_PER_ROW = DEF_KEYS_PER_ROW
) (
   input  logic              clock,
   input  logic              reset,
   kptm_req_if.sink          req_ch,
   kptm_rsp_if.source        rsp_ch,
   input  logic              csr_write_enable,
   input  logic [RATE_W-1:0] csr_write_data
);

   kptm_cmd_type    cmd;
   kptm_status_type status;

   kptm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   kptm_datapath #(
      .KEY_ROWS     (KEY_ROWS),
      .KEYS_PER_ROW (KEYS_PER_ROW)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_kind           (req_ch.kind),
      .req_port_address   (req_ch.port_address),
      .req_cycle_now      (req_ch.cycle_now),
      .req_key_matrix     (req_ch.key_matrix),
      .cmd                (cmd),
      .status             (status),
      .rsp_read_data      (rsp_ch.read_data),
      .rsp_tone_frequency (rsp_ch.tone_frequency),
      .rsp_tone_update    (rsp_ch.tone_update)
   );

endmodule

>>> hdl/kptm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kptm_ctrl
// Sequencer: request handshake, divide step count and response valid.
// ----------------------------------------------------------------------------
module kptm_ctrl import kptm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  kptm_status_type status,
   output kptm_cmd_type    cmd
);

   kptm_state_type          state_ff, state_in;
   logic [STEP_CNT_W-1:0]   step_ff, step_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_free;
   logic                    step_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_last = (step_ff == STEP_CNT_W'(QUOT_W - 1));
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && out_free && status.req_is_sync)
               state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_DIV;
         ST_DIV: begin
            if (step_last)
               state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready       = out_free;
            cmd.accept      = req_valid && out_free;
            cmd.load_simple = req_valid && out_free && !status.req_is_sync;
         end
         ST_MUL:  cmd.mul = 1'b1;
         ST_DIV:  cmd.div_step = 1'b1;
         ST_DONE: cmd.load_freq = out_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (state_ff == ST_MUL)
         step_in = '0;
      else if (state_ff == ST_DIV)
         step_in = step_ff + 1'b1;
   end

   always_comb begin
      if (cmd.load_simple || cmd.load_freq)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hdl/kptm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kptm_datapath
// Key matrix scan, toggle accounting and shift-subtract tone divider.
// ----------------------------------------------------------------------------
module kptm_datapath import kptm_pkg::*; #(
   parameter int KEY_ROWS     = DEF_KEY_ROWS,
   parameter int KEYS_PER_ROW = DEF_KEYS_PER_ROW
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [RATE_W-1:0]   csr_write_data,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [ADDR_W-1:0]   req_port_address,
   input  logic [TIME_W-1:0]   req_cycle_now,
   input  logic [MATRIX_W-1:0] req_key_matrix,
   input  kptm_cmd_type        cmd,
   output kptm_status_type     status,
   output logic [DATA_W-1:0]   rsp_read_data,
   output logic [FREQ_W-1:0]   rsp_tone_frequency,
   output logic                rsp_tone_update
);

   logic [RATE_W-1:0]  rate_ff;
   logic [TIME_W-1:0]  last_time_ff;
   logic               time_valid_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               no_data_ff;
   logic [QUOT_W-1:0]  quo_ff;
   logic [TOTAL_W-1:0] rem_ff;
   logic [DATA_W-1:0]  read_data_ff;
   logic [FREQ_W-1:0]  freq_ff;
   logic               update_ff;

   logic               port_hit;
   logic [DATA_W-1:0]  rows_or;
   logic [DATA_W-1:0]  read_value;
   logic [TIME_W-1:0]  gap;
   logic [TOTAL_W:0]   total_sum;
   logic               is_write;
   logic [QUOT_W-1:0]  product;
   logic [TOTAL_W:0]   trial;
   logic [TOTAL_W:0]   trial_diff;
   logic               trial_ge;
   logic [FREQ_W-1:0]  freq_value;

   assign port_hit           = (req_port_address[7:0] == KBD_PORT);
   assign status.req_is_sync = (req_kind == KIND_SYNC);
   assign is_write           = cmd.accept && (req_kind == KIND_WRITE) && port_hit;

   // rows whose select bit is low are ORed together
   always_comb begin
      rows_or = '0;
      for (int i = 0; i < KEY_ROWS; i++) begin
         if (i < 8) begin
            if (!req_port_address[8 + i]) begin
               for (int k = 0; k < KEYS_PER_ROW; k++) begin
                  if ((i * KEYS_PER_ROW + k) < MATRIX_W && k < DATA_W)
                     rows_or[k] = rows_or[k] | req_key_matrix[i * KEYS_PER_ROW + k];
               end
            end
         end
      end
   end

   assign read_value = (req_kind == KIND_READ && port_hit) ? ~rows_or : IDLE_READ;

   assign gap = (req_cycle_now >= last_time_ff) ? req_cycle_now - last_time_ff
                                                 : last_time_ff - req_cycle_now;
   assign total_sum = {1'b0, total_ff} + {{(TOTAL_W + 1 - TIME_W){1'b0}}, gap};

   always_comb begin
      if (!time_valid_ff) begin
         count_in = '0;
         total_in = '0;
      end else begin
         count_in = (&count_ff) ? count_ff : count_ff + 1'b1;
         total_in = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
      end
   end

   assign product = rate_ff[RATE_W-1:1] * count_ff;

   assign trial      = {rem_ff, quo_ff[QUOT_W-1]};
   assign trial_ge   = (trial >= {1'b0, total_ff});
   assign trial_diff = trial - {1'b0, total_ff};

   always_comb begin
      if (no_data_ff)
         freq_value = '0;
      else if (|quo_ff[QUOT_W-1:FREQ_W])
         freq_value = FREQ_MAX;
      else
         freq_value = quo_ff[FREQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff       <= RATE_RESET;
         last_time_ff  <= '0;
         time_valid_ff <= 1'b0;
         count_ff      <= '0;
         total_ff      <= '0;
      end else begin
         if (csr_write_enable)
            rate_ff <= csr_write_data;
         if (is_write) begin
            last_time_ff  <= req_cycle_now;
            time_valid_ff <= 1'b1;
            count_ff      <= count_in;
            total_ff      <= total_in;
         end else if (cmd.accept && status.req_is_sync) begin
            time_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && status.req_is_sync)
         no_data_ff <= !(time_valid_ff && count_ff != '0 && total_ff != '0);
      if (cmd.mul) begin
         quo_ff <= product;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[QUOT_W-2:0], trial_ge};
         rem_ff <= trial_ge ? trial_diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
      end
      if (cmd.load_simple) begin
         read_data_ff <= read_value;
         freq_ff      <= '0;
         update_ff    <= 1'b0;
      end else if (cmd.load_freq) begin
         read_data_ff <= IDLE_READ;
         freq_ff      <= freq_value;
         update_ff    <= 1'b1;
      end
   end

   assign rsp_read_data      = read_data_ff;
   assign rsp_tone_frequency = freq_ff;
   assign rsp_tone_update    = update_ff;

endmodule

>>> dv/kptm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kptm_checker
// Watches the request and response channels of the keyboard port and tone
// meter. It keeps its own copy of the toggle state and the clock rate, works
// out the response of every accepted request, and compares each accepted
// response field by field with the oldest one still awaited.
// ----------------------------------------------------------------------------
module kptm_checker import kptm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   kptm_req_if               req_ch,
   kptm_rsp_if               rsp_ch,
   input  logic              csr_write_enable,
   input  logic [RATE_W-1:0] csr_write_data,
   output int                mismatch_count,
   output int                responses_awaited
);

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [FREQ_W-1:0] tone_frequency;
      logic              tone_update;
   } port_response_type;

   port_response_type awaited_responses[$];

   logic [RATE_W-1:0]  clock_rate;
   logic [TIME_W-1:0]  last_toggle;
   logic               toggle_seen;
   logic [COUNT_W-1:0] toggles;
   logic [TOTAL_W-1:0] toggle_sum;

   initial begin
      mismatch_count    = 0;
      responses_awaited = 0;
   end

   task automatic report_failure(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic logic [DATA_W-1:0] key_scan(input logic [ADDR_W-1:0]   addr,
                                                  input logic [MATRIX_W-1:0] matrix);
      logic [DATA_W-1:0] rows_or;
      rows_or = '0;
      if (addr[7:0] != KBD_PORT) return IDLE_READ;
      // a low address bit in the high byte selects its key row
      for (int r = 0; r < DEF_KEY_ROWS; r++) begin
         if (!addr[8 + r]) begin
            rows_or |= DATA_W'(matrix[r * DEF_KEYS_PER_ROW +: DEF_KEYS_PER_ROW]);
         end
      end
      return ~rows_or;
   endfunction

   function automatic void record_toggle(input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0]  gap;
      logic [TOTAL_W:0]   sum;
      if (!toggle_seen) begin
         toggles    = '0;
         toggle_sum = '0;
      end else begin
         gap = (now >= last_toggle) ? now - last_toggle : last_toggle - now;
         if (toggles != '1) toggles = toggles + 1'b1;
         sum        = {1'b0, toggle_sum} + (TOTAL_W + 1)'(gap);
         toggle_sum = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
      end
      last_toggle = now;
      toggle_seen = 1'b1;
   endfunction

   function automatic logic [FREQ_W-1:0] measure_tone();
      logic [63:0]       product;
      logic [FREQ_W-1:0] freq;
      freq = '0;
      if (toggle_seen && toggles != '0 && toggle_sum != '0) begin
         product = 64'(clock_rate >> 1) * 64'(toggles);
         product = product / 64'(toggle_sum);
         freq    = (product > 64'(FREQ_MAX)) ? FREQ_MAX : product[FREQ_W-1:0];
      end
      toggle_seen = 1'b0;
      return freq;
   endfunction

   function automatic port_response_type next_response(input logic [KIND_W-1:0]   kind,
                                                       input logic [ADDR_W-1:0]   addr,
                                                       input logic [TIME_W-1:0]   now,
                                                       input logic [MATRIX_W-1:0] matrix);
      port_response_type resp;
      resp.read_data      = IDLE_READ;
      resp.tone_frequency = '0;
      resp.tone_update    = 1'b0;
      case (kind)
         KIND_READ: begin
            resp.read_data = key_scan(addr, matrix);
         end
         KIND_WRITE: begin
            if (addr[7:0] == KBD_PORT) record_toggle(now);
         end
         KIND_SYNC: begin
            resp.tone_frequency = measure_tone();
            resp.tone_update    = 1'b1;
         end
         default: begin
         end
      endcase
      return resp;
   endfunction

   always @(posedge clock) begin
      port_response_type want;
      if (reset) begin
         clock_rate  = RATE_RESET;
         last_toggle = '0;
         toggle_seen = 1'b0;
         toggles     = '0;
         toggle_sum  = '0;
         awaited_responses.delete();
      end else begin
         if (csr_write_enable) clock_rate = csr_write_data;
         // response first: it can never belong to a request taken at this edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_responses.size() == 0) begin
               report_failure($sformatf("response with no request pending (read_data %02h)",
                                        rsp_ch.read_data));
            end else begin
               want = awaited_responses.pop_front();
               if (rsp_ch.read_data !== want.read_data)
                  report_failure($sformatf("read_data got %02h expected %02h",
                                           rsp_ch.read_data, want.read_data));
               if (rsp_ch.tone_frequency !== want.tone_frequency)
                  report_failure($sformatf("tone_frequency got %0d expected %0d",
                                           rsp_ch.tone_frequency, want.tone_frequency));
               if (rsp_ch.tone_update !== want.tone_update)
                  report_failure($sformatf("tone_update got %b expected %b",
                                           rsp_ch.tone_update, want.tone_update));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            awaited_responses.push_back(next_response(req_ch.kind, req_ch.port_address,
                                                      req_ch.cycle_now, req_ch.key_matrix));
         end
      end
      responses_awaited = awaited_responses.size();
   end

endmodule

>>> dv/tb_keyboard_port_and_tone_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyboard_port_and_tone_meter
// Drives the keyboard port and tone meter with directed port reads, speaker
// toggles and frame syncs, then with random toggle trains and noise under
// several clock rates, with bursty requests and a stalling response side.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_keyboard_port_and_tone_meter;
   import kptm_pkg::*;

   localparam int                WATCHDOG_LIMIT    = 2000;
   localparam int                SETTLE_CYCLES     = 60;
   localparam int                LONG_HOLD_CYCLES  = 200;
   localparam int                ITEMS_PER_PHASE   = 300;
   localparam logic [KIND_W-1:0] KIND_UNUSED       = 2'd3;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic [RATE_W-1:0] csr_write_data   = '0;

   int mismatch_count;
   int responses_awaited;
   int idle_cycles     = 0;
   int responses_taken = 0;
   int burst_left      = 1;
   int phase_requests  = 0;

   kptm_req_if req_ch ();
   kptm_rsp_if rsp_ch ();

   keyboard_port_and_tone_meter dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   kptm_checker tone_meter_checker (
      .clock             (clock),
      .reset             (reset),
      .req_ch            (req_ch),
      .rsp_ch            (rsp_ch),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .mismatch_count    (mismatch_count),
      .responses_awaited (responses_awaited)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: cycles without any handshake
   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready) responses_taken++;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // response side: stretches of varying stall density, plus two long hold-offs
   initial begin
      int stall_left;
      int stretch_left;
      int stall_odds;
      int holds_done;
      stall_left   = 0;
      stretch_left = 0;
      stall_odds   = 0;
      holds_done   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(20, 150);
            stall_odds   = $urandom_range(0, 3);
         end
         stretch_left--;
         if ((holds_done == 0 && responses_taken >= 400) ||
             (holds_done == 1 && responses_taken >= 1100)) begin
            holds_done++;
            stall_left = LONG_HOLD_CYCLES;
         end else if (stall_left == 0 && stall_odds != 0 &&
                      $urandom_range(0, 7) < stall_odds) begin
            stall_left = $urandom_range(1, 2 * stall_odds);
         end
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   function automatic logic [MATRIX_W-1:0] random_keys();
      return MATRIX_W'({$urandom, $urandom});
   endfunction

   function automatic logic [ADDR_W-1:0] kbd_address();
      return {8'($urandom), KBD_PORT};
   endfunction

   task automatic send_request(input logic [KIND_W-1:0]   kind,
                               input logic [ADDR_W-1:0]   addr,
                               input logic [TIME_W-1:0]   now,
                               input logic [MATRIX_W-1:0] matrix);
      int gap;
      @(negedge clock);
      req_ch.valid        = 1'b1;
      req_ch.kind         = kind;
      req_ch.port_address = addr;
      req_ch.cycle_now    = now;
      req_ch.key_matrix   = matrix;
      do @(posedge clock); while (!req_ch.ready);
      if (kind == KIND_SYNC || (kind != KIND_UNUSED && addr[7:0] == KBD_PORT))
         phase_requests++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (responses_awaited != 0) @(negedge clock);
   endtask

   task automatic set_clock_rate(input logic [RATE_W-1:0] rate);
      wait_until_drained();
      csr_write_enable = 1'b1;
      csr_write_data   = rate;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic send_random_item();
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] addr;
      int                pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)      kind = KIND_READ;
      else if (pick < 75) kind = KIND_WRITE;
      else if (pick < 92) kind = KIND_SYNC;
      else                kind = KIND_UNUSED;
      addr = ADDR_W'($urandom);
      if ($urandom_range(0, 9) < 7) addr[7:0] = KBD_PORT;
      send_request(kind, addr, TIME_W'($urandom), random_keys());
   endtask

   // a speaker toggle train with keyboard reads mixed in, usually closed by a sync
   task automatic send_tone_train();
      int                edges;
      int                half_period;
      logic [TIME_W-1:0] now;
      edges       = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
      half_period = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3)
                                                : $urandom_range(4, 40000);
      now         = TIME_W'($urandom);
      repeat (edges) begin
         if ($urandom_range(0, 3) == 0)
            send_request(KIND_READ, kbd_address(), TIME_W'($urandom), random_keys());
         send_request(KIND_WRITE, kbd_address(), now, random_keys());
         now = now + TIME_W'(half_period + $urandom_range(0, 3));
      end
      if ($urandom_range(0, 9) != 0)
         send_request(KIND_SYNC, ADDR_W'($urandom), TIME_W'($urandom), random_keys());
   endtask

   task automatic run_random_phase();
      phase_requests = 0;
      while (phase_requests < ITEMS_PER_PHASE) begin
         if ($urandom_range(0, 9) < 6) send_tone_train();
         else send_random_item();
      end
   endtask

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.kind         = KIND_READ;
      req_ch.port_address = '0;
      req_ch.cycle_now    = '0;
      req_ch.key_matrix   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // keyboard scan: all rows, no rows, other port, single rows
      send_request(KIND_READ, 16'h00FE, '0, '1);
      send_request(KIND_READ, 16'hFFFE, '1, '1);
      send_request(KIND_READ, 16'h00FF, '0, random_keys());
      send_request(KIND_READ, 16'hFEFE, '0, random_keys());
      send_request(KIND_READ, 16'h7FFE, '0, '1);
      // sync with nothing recorded, then after a lone toggle
      send_request(KIND_SYNC, 16'h00FE, '0, '0);
      send_request(KIND_WRITE, 16'h00FE, '0, '0);
      send_request(KIND_SYNC, 16'hFFFF, '1, '1);
      // zero total
      send_request(KIND_WRITE, 16'h00FE, TIME_W'(100), '0);
      send_request(KIND_WRITE, 16'hFFFE, TIME_W'(100), '0);
      send_request(KIND_SYNC, 16'h0000, '0, '0);
      // ignored requests
      send_request(KIND_WRITE, 16'h12FD, TIME_W'(500), '0);
      send_request(KIND_UNUSED, 16'h00FE, TIME_W'(700), '1);
      // gaps across the ends of the cycle counter, then a repeated sync
      send_request(KIND_WRITE, 16'h00FE, '1, '0);
      send_request(KIND_WRITE, 16'h00FE, '0, '0);
      send_request(KIND_WRITE, 16'h00FE, '1, '0);
      send_request(KIND_SYNC, 16'h00FE, '0, '0);
      send_request(KIND_SYNC, 16'h00FE, '0, '0);
      // first toggle after a sync starts a new count
      send_request(KIND_WRITE, 16'h00FE, TIME_W'(10), '0);
      send_request(KIND_WRITE, 16'h00FE, TIME_W'(30), '0);
      send_request(KIND_SYNC, 16'h00FE, '0, '0);
      run_random_phase();

      set_clock_rate(RATE_W'(1000000));
      run_random_phase();

      set_clock_rate('1);
      // many toggles in almost no time: frequency clips
      send_request(KIND_WRITE, 16'h00FE, TIME_W'(5), '0);
      send_request(KIND_WRITE, 16'h00FE, TIME_W'(5), '0);
      send_request(KIND_WRITE, 16'h00FE, TIME_W'(5), '0);
      send_request(KIND_WRITE, 16'h00FE, TIME_W'(5), '0);
      send_request(KIND_WRITE, 16'h00FE, TIME_W'(6), '0);
      send_request(KIND_SYNC, 16'h00FE, '0, '0);
      run_random_phase();

      set_clock_rate(RATE_W'($urandom_range(1000000, 33554431)));
      run_random_phase();

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
